// ===== rtl/core/hashed_name_offset_lookup_core_defines.svh =====
// ----------------------------------------------------------------------------
// hashed name offset lookup core - assertion macros
// concurrent checks clocked on clk and held off while rst is high
// ----------------------------------------------------------------------------
`ifndef HASHED_NAME_OFFSET_LOOKUP_CORE_DEFINES_SVH
`define HASHED_NAME_OFFSET_LOOKUP_CORE_DEFINES_SVH

// same-cycle implication
`define HNOL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HNOL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/hnol_pkg.sv =====
// ----------------------------------------------------------------------------
// hnol_pkg
// shared types, codes and constants of the hashed name offset lookup core
// ----------------------------------------------------------------------------
`default_nettype none

package hnol_pkg;

  localparam int OP_W       = 2;
  localparam int INDEX_W    = 8;
  localparam int HASH_W     = 32;
  localparam int BANK_W     = 4;
  localparam int OFFSET_W   = 21;
  localparam int BYTE_W     = 8;
  localparam int STATUS_W   = 2;
  localparam int OFS_OUT_W  = 20;
  localparam int POS_W      = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int COUNT_W    = 9;
  localparam int BCOUNT_W   = 4;
  localparam int MASK_W     = 8;

  localparam logic [HASH_W-1:0] HASH_PRIME = 32'h0100_0193;
  localparam logic [HASH_W-1:0] HASH_BASIS = 32'h811c_9dc5;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BANK_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BANK_MASK   = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_HASH   = 2'd0,
    OP_WRITE_OFFSET = 2'd1,
    OP_NAME_BYTE    = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_FOUND      = 2'd0,
    STAT_BANK_RANGE = 2'd1,
    STAT_UNKNOWN    = 2'd2,
    STAT_ABSENT     = 2'd3
  } status_t;

  // lookup request handed from the front end to the search sequencer
  typedef struct packed {
    logic              go;
    logic              bank_ok;
    logic              present;
    logic [BANK_W-1:0] bank;
    logic [HASH_W-1:0] hash;
  } launch_t;

  typedef struct packed {
    status_t              status;
    logic [OFS_OUT_W-1:0] bank_offset;
    logic [POS_W-1:0]     position;
    logic [HASH_W-1:0]    hash;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/hnol_ram.sv =====
// ----------------------------------------------------------------------------
// hnol_ram
// generic simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module hnol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/hnol_hash.sv =====
// ----------------------------------------------------------------------------
// hnol_hash
// running fnv-1a hash, one name byte folded in per item
// ----------------------------------------------------------------------------
`default_nettype none

module hnol_hash (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        byte_en,
  input  wire logic                        last_byte,
  input  wire logic [hnol_pkg::BYTE_W-1:0] name_byte,
  output logic      [hnol_pkg::HASH_W-1:0] hash_next
);

  import hnol_pkg::*;

  logic [HASH_W-1:0] running_hash;

  // xor the byte in, then multiply by the prime modulo 2^32
  assign hash_next = (running_hash ^ {{(HASH_W-BYTE_W){1'b0}}, name_byte}) * HASH_PRIME;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= HASH_BASIS;
    end else if (byte_en) begin
      running_hash <= last_byte ? HASH_BASIS : hash_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hnol_search.sv =====
// ----------------------------------------------------------------------------
// hnol_search
// binary search sequencer over the node table, then bank offset check
// ----------------------------------------------------------------------------
`default_nettype none

module hnol_search #(
  parameter int MAX_ENTRIES = 256,
  parameter int NUM_BANKS   = 8,
  parameter int OFFSET_BITS = 20
) (
  input  wire logic                                            clk,
  input  wire logic                                            rst,
  input  wire hnol_pkg::launch_t                               launch,
  input  wire logic [$clog2(MAX_ENTRIES+1)-1:0]                count,
  output logic      [$clog2(MAX_ENTRIES)-1:0]                  node_raddr,
  input  wire logic [hnol_pkg::HASH_W-1:0]                     node_rdata,
  output logic      [$clog2(MAX_ENTRIES*NUM_BANKS)-1:0]        ofs_raddr,
  input  wire logic [OFFSET_BITS:0]                            ofs_rdata,
  output logic                                                 busy,
  output logic                                                 done,
  output hnol_pkg::result_t                                    result
);

  import hnol_pkg::*;

  localparam int IW  = $clog2(MAX_ENTRIES);
  localparam int CW  = $clog2(MAX_ENTRIES+1);
  localparam int OAW = $clog2(MAX_ENTRIES*NUM_BANKS);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ADDR  = 4'b0010,
    S_CMP   = 4'b0100,
    S_CHK   = 4'b1000
  } state_t;

  state_t            state;
  logic [CW-1:0]     lo;
  logic [CW-1:0]     hi;
  logic [IW-1:0]     mid_r;
  logic [HASH_W-1:0] hash_r;
  logic [BANK_W-1:0] bank_r;
  logic              present_r;
  logic [CW-1:0]     mid;

  // floor midpoint of the live range, valid while lo < hi
  assign mid        = lo + ((hi - lo - CW'(1)) >> 1);
  assign node_raddr = IW'(mid);
  assign ofs_raddr  = OAW'(mid_r) * OAW'(NUM_BANKS) + OAW'(bank_r);
  assign busy       = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (launch.go) begin
            hash_r    <= launch.hash;
            bank_r    <= launch.bank;
            present_r <= launch.present;
            if (!launch.bank_ok) begin
              result <= '{STAT_BANK_RANGE, '0, '0, launch.hash};
              done   <= 1'b1;
            end else begin
              lo    <= '0;
              hi    <= count;
              state <= S_ADDR;
            end
          end
        end
        S_ADDR: begin
          if (lo >= hi) begin
            result <= '{STAT_UNKNOWN, '0, '0, hash_r};
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            mid_r <= IW'(mid);
            state <= S_CMP;
          end
        end
        S_CMP: begin
          // equality and magnitude compare against the probed entry
          if (node_rdata == hash_r) begin
            state <= S_CHK;
          end else if (node_rdata < hash_r) begin
            lo    <= CW'(mid_r) + CW'(1);
            state <= S_ADDR;
          end else begin
            hi    <= CW'(mid_r);
            state <= S_ADDR;
          end
        end
        S_CHK: begin
          if (ofs_rdata[OFFSET_BITS] || !present_r) begin
            result <= '{STAT_ABSENT, '0, POS_W'(mid_r), hash_r};
          end else begin
            result <= '{STAT_FOUND, OFS_OUT_W'(ofs_rdata), POS_W'(mid_r), hash_r};
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hashed_name_offset_lookup_core.sv =====
// ----------------------------------------------------------------------------
// hashed_name_offset_lookup_core - fnv-1a name hash and sorted table lookup
// writes and non-final name bytes: one item per cycle while the sequencer is idle
// final byte: a search of k table probes, k <= log2(n)+1, then the result strobe;
// hit and miss with equal k take as long; a bank reject answers in the next cycle
// sync reset: config zero, fsm idle, hash at basis, tables undefined until written
// ----------------------------------------------------------------------------
`default_nettype none

`include "hashed_name_offset_lookup_core_defines.svh"

module hashed_name_offset_lookup_core #(
  parameter int MAX_ENTRIES = 256,
  parameter int NUM_BANKS   = 8,
  parameter int OFFSET_BITS = 20
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration write port
  input  wire logic                                cfg_we,
  input  wire logic [hnol_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [hnol_pkg::CFG_DATA_W-1:0]     cfg_data,
  // command side
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [hnol_pkg::OP_W-1:0]           operation,
  input  wire logic [hnol_pkg::INDEX_W-1:0]        entry_index,
  input  wire logic [hnol_pkg::HASH_W-1:0]         entry_hash,
  input  wire logic [hnol_pkg::BANK_W-1:0]         bank_index,
  input  wire logic signed [hnol_pkg::OFFSET_W-1:0] offset_value,
  input  wire logic [hnol_pkg::BYTE_W-1:0]         name_byte,
  input  wire logic                                last_byte,
  // result side, one-cycle strobe
  output logic                                     done,
  output logic [hnol_pkg::STATUS_W-1:0]            status,
  output logic [hnol_pkg::OFS_OUT_W-1:0]           bank_offset,
  output logic [hnol_pkg::POS_W-1:0]               entry_position,
  output logic [hnol_pkg::HASH_W-1:0]              name_hash
);

  import hnol_pkg::*;

  localparam int IW  = $clog2(MAX_ENTRIES);
  localparam int CW  = $clog2(MAX_ENTRIES+1);
  localparam int OAW = $clog2(MAX_ENTRIES*NUM_BANKS);
  localparam int SW  = OFFSET_BITS + 1;

  // configuration registers
  logic [COUNT_W-1:0]  entry_count;
  logic [BCOUNT_W-1:0] bank_count;
  logic [MASK_W-1:0]   bank_present_mask;

  logic              accept;
  logic              is_name;
  logic              idx_ok;
  logic              wbank_ok;
  logic [HASH_W-1:0] hash_next;
  logic [BANK_W:0]   banks_eff;
  logic [CW-1:0]     count_eff;
  launch_t           launch;
  result_t           result;

  logic [IW-1:0]     node_raddr;
  logic [HASH_W-1:0] node_rdata;
  logic [OAW-1:0]    ofs_raddr;
  logic [OAW-1:0]    ofs_waddr;
  logic [SW-1:0]     ofs_rdata;
  logic [SW-1:0]     ofs_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count       <= '0;
      bank_count        <= '0;
      bank_present_mask <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENTRY_COUNT: entry_count       <= cfg_data;
        CFG_BANK_COUNT:  bank_count        <= cfg_data[BCOUNT_W-1:0];
        CFG_BANK_MASK:   bank_present_mask <= cfg_data[MASK_W-1:0];
        default: begin
          // unused register index, write dropped
        end
      endcase
    end
  end

  // an item is taken whenever start is high and the sequencer is idle
  assign accept  = start && !busy;
  assign is_name = (operation == OP_NAME_BYTE);

  // table writes out of range are dropped
  assign idx_ok   = (32'(entry_index) < MAX_ENTRIES);
  assign wbank_ok = (32'(bank_index) < NUM_BANKS);

  // oversized counts saturate at the built sizes
  assign banks_eff = (32'(bank_count) > NUM_BANKS) ? (BANK_W+1)'(NUM_BANKS)
                                                   : {1'b0, bank_count};
  assign count_eff = (32'(entry_count) > MAX_ENTRIES) ? CW'(MAX_ENTRIES)
                                                      : CW'(entry_count);

  // running hash, updated on every accepted name byte
  hnol_hash u_hash (
    .clk       (clk),
    .rst       (rst),
    .byte_en   (accept && is_name),
    .last_byte (last_byte),
    .name_byte (name_byte),
    .hash_next (hash_next)
  );

  // final byte launches the lookup; banks past 7 have no storage at all
  assign launch.go      = accept && is_name && last_byte;
  assign launch.bank_ok = ({1'b0, bank_index} < banks_eff);
  assign launch.present = !bank_index[BANK_W-1] && bank_present_mask[bank_index[2:0]];
  assign launch.bank    = bank_index;
  assign launch.hash    = hash_next;

  // node hash table, ascending by software
  hnol_ram #(
    .WIDTH (HASH_W),
    .DEPTH (MAX_ENTRIES)
  ) u_node_ram (
    .clk   (clk),
    .we    (accept && (operation == OP_WRITE_HASH) && idx_ok),
    .waddr (IW'(entry_index)),
    .wdata (entry_hash),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  // per node and bank offsets, row major by node; stored sign-extended to width
  assign ofs_waddr = OAW'(entry_index) * OAW'(NUM_BANKS) + OAW'(bank_index);
  assign ofs_wdata = SW'(offset_value);

  hnol_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_ENTRIES*NUM_BANKS)
  ) u_ofs_ram (
    .clk   (clk),
    .we    (accept && (operation == OP_WRITE_OFFSET) && idx_ok && wbank_ok),
    .waddr (ofs_waddr),
    .wdata (ofs_wdata),
    .raddr (ofs_raddr),
    .rdata (ofs_rdata)
  );

  // binary search and offset check sequencer
  hnol_search #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .NUM_BANKS   (NUM_BANKS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_search (
    .clk        (clk),
    .rst        (rst),
    .launch     (launch),
    .count      (count_eff),
    .node_raddr (node_raddr),
    .node_rdata (node_rdata),
    .ofs_raddr  (ofs_raddr),
    .ofs_rdata  (ofs_rdata),
    .busy       (busy),
    .done       (done),
    .result     (result)
  );

  assign status         = result.status;
  assign bank_offset    = result.bank_offset;
  assign entry_position = result.position;
  assign name_hash      = result.hash;

  // result strobe coincides with the return to idle
  `HNOL_ASSERT_IMP(a_done_idle, done, !busy, "result strobe while busy")
  // a final byte either answers at once or starts the search
  `HNOL_ASSERT_NXT(a_last_launch, accept && is_name && last_byte, busy || done, "lookup lost")
  // a bank reject or an unknown name carries neither offset nor position
  `HNOL_ASSERT_IMP(a_miss_clean, done && (status != STAT_FOUND) && (status != STAT_ABSENT),
                   (bank_offset == '0) && (entry_position == '0), "miss result not clear")

endmodule

`default_nettype wire

// ===== sim/hashed_name_offset_lookup_core_tb.sv =====
// ----------------------------------------------------------------------------
// hashed_name_offset_lookup_core_tb - self-checking bench for the lookup core
// a queue-fed driver sends table writes and name bytes, a clocked monitor
// predicts every lookup result and compares it field by field with the core
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_name_offset_lookup_core_tb;
  import hnol_pkg::*;

  localparam int MAX_ENTRIES  = 256;
  localparam int NUM_BANKS    = 8;
  localparam int NAME_MAX     = 8;
  localparam int DRAIN_CYCLES = 48;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int MAX_REPORTS  = 10;

  // the fourth operation code has no meaning and must be ignored
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

  // one command item as it sits on the input ports
  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [INDEX_W-1:0]  idx;
    logic [HASH_W-1:0]   ehash;
    logic [BANK_W-1:0]   bank;
    logic [OFFSET_W-1:0] ofs;
    logic [BYTE_W-1:0]   nbyte;
    logic                last;
  } cmd_t;

  // clock, reset and every input start at a known value
  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    start = 1'b0;
  logic [OP_W-1:0]         operation = '0;
  logic [INDEX_W-1:0]      entry_index = '0;
  logic [HASH_W-1:0]       entry_hash = '0;
  logic [BANK_W-1:0]       bank_index = '0;
  logic signed [OFFSET_W-1:0] offset_value = '0;
  logic [BYTE_W-1:0]       name_byte = '0;
  logic                    last_byte = 1'b0;

  logic                    busy;
  logic                    done;
  logic [STATUS_W-1:0]     status;
  logic [OFS_OUT_W-1:0]    bank_offset;
  logic [POS_W-1:0]        entry_position;
  logic [HASH_W-1:0]       name_hash;

  hashed_name_offset_lookup_core #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .NUM_BANKS  (NUM_BANKS),
    .OFFSET_BITS(20)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .start         (start),
    .busy          (busy),
    .operation     (operation),
    .entry_index   (entry_index),
    .entry_hash    (entry_hash),
    .bank_index    (bank_index),
    .offset_value  (offset_value),
    .name_byte     (name_byte),
    .last_byte     (last_byte),
    .done          (done),
    .status        (status),
    .bank_offset   (bank_offset),
    .entry_position(entry_position),
    .name_hash     (name_hash)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // predictor state, owned by the monitor
  // --------------------------------------------------------------------------
  logic [HASH_W-1:0]          fold_hash;
  logic [HASH_W-1:0]          node_hash_q[MAX_ENTRIES];
  logic signed [OFFSET_W-1:0] node_ofs_q[MAX_ENTRIES*NUM_BANKS];
  logic [COUNT_W-1:0]         entry_count_q;
  logic [BCOUNT_W-1:0]        bank_count_q;
  logic [MASK_W-1:0]          bank_mask_q;

  result_t lookup_expected[$];   // lookups accepted but not yet answered
  int      mismatch_count = 0;
  int      accepted_count = 0;
  int      cycle_count = 0;
  logic    taken = 1'b0;         // item went in at the last rising edge

  // handshake bookkeeping shared by driver and stimulus
  cmd_t pending_cmds[$];
  int   pushed_count = 0;
  int   ignored_count = 0;
  int   gap_left = 0;
  int   calm_left = 0;

  // stimulus-side picture of the tables, only to keep lookups legal
  logic [63:0]       name_word[MAX_ENTRIES];
  int                name_len[MAX_ENTRIES];
  bit   [HASH_W-1:0] gen_hash[MAX_ENTRIES];
  bit                ofs_written[MAX_ENTRIES*NUM_BANKS];
  int                table_size = 0;
  int                live_banks = 0;

  // one fnv-1a round: xor the byte in, multiply by the prime modulo 2^32
  function automatic logic [HASH_W-1:0] fnv_fold(input logic [HASH_W-1:0] h,
                                                 input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
    return x * HASH_PRIME;
  endfunction

  function automatic logic [HASH_W-1:0] hash_of_name(input logic [63:0] word, input int len);
    logic [HASH_W-1:0] h;
    h = HASH_BASIS;
    for (int k = 0; k < len; k++) h = fnv_fold(h, word[8*k +: 8]);
    return h;
  endfunction

  // advance the predicted core by one item, returns 1 when a lookup answers
  function automatic bit lookup_step(input cmd_t c, output result_t r);
    logic [HASH_W-1:0]          h;
    logic signed [OFFSET_W-1:0] ofs;
    int                         lo, hi, mid, pos, nb;
    bit                         hit;
    r = '0;
    if (c.op == OP_WRITE_HASH) begin
      node_hash_q[c.idx] = c.ehash;
      return 1'b0;
    end
    if (c.op == OP_WRITE_OFFSET) begin
      // writes to banks past the last one fall on the floor
      if (int'(c.bank) < NUM_BANKS) node_ofs_q[int'(c.idx)*NUM_BANKS + int'(c.bank)] = c.ofs;
      return 1'b0;
    end
    if (c.op != OP_NAME_BYTE) return 1'b0;

    h = fnv_fold(fold_hash, c.nbyte);
    if (!c.last) begin
      fold_hash = h;
      return 1'b0;
    end
    fold_hash = HASH_BASIS;
    r.hash = h;

    // an oversized bank count saturates at the bank total
    nb = (int'(bank_count_q) > NUM_BANKS) ? NUM_BANKS : int'(bank_count_q);
    if (int'(c.bank) >= nb) begin
      r.status = STAT_BANK_RANGE;
      return 1'b1;
    end

    // binary search over the live range, first hit wins
    lo  = 0;
    hi  = (int'(entry_count_q) > MAX_ENTRIES) ? MAX_ENTRIES : int'(entry_count_q);
    hit = 1'b0;
    pos = 0;
    while (lo < hi && !hit) begin
      mid = lo + (hi - 1 - lo) / 2;
      if (node_hash_q[mid] == h) begin
        hit = 1'b1;
        pos = mid;
      end else if (node_hash_q[mid] < h) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    if (!hit) begin
      r.status = STAT_UNKNOWN;
      return 1'b1;
    end

    r.position = pos[POS_W-1:0];
    ofs = node_ofs_q[pos*NUM_BANKS + int'(c.bank)];
    // negative offset or bank without storage means the node is not there
    if (ofs < 0 || !bank_mask_q[c.bank[2:0]]) begin
      r.status = STAT_ABSENT;
    end else begin
      r.status      = STAT_FOUND;
      r.bank_offset = ofs[OFS_OUT_W-1:0];
    end
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // monitor: config tracking, result check, prediction of accepted items
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cmd_t    c;
    result_t want;
    result_t got;
    if (rst) begin
      fold_hash     = HASH_BASIS;
      entry_count_q = '0;
      bank_count_q  = '0;
      bank_mask_q   = '0;
      taken <= 1'b0;
    end else begin
      // results first, so an item accepted on this edge queues behind them
      if (done) begin
        got.status      = status_t'(status);
        got.bank_offset = bank_offset;
        got.position    = entry_position;
        got.hash        = name_hash;
        if (lookup_expected.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result: status %0d offset %0d position %0d hash %08h",
                     got.status, got.bank_offset, got.position, got.hash);
        end else begin
          want = lookup_expected.pop_front();
          if (got != want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("mismatch: expected status %0d offset %0d position %0d hash %08h",
                       want.status, want.bank_offset, want.position, want.hash,
                       " / got status %0d offset %0d position %0d hash %08h",
                       got.status, got.bank_offset, got.position, got.hash);
          end
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_ENTRY_COUNT: entry_count_q = cfg_data[COUNT_W-1:0];
          CFG_BANK_COUNT:  bank_count_q  = cfg_data[BCOUNT_W-1:0];
          CFG_BANK_MASK:   bank_mask_q   = cfg_data[MASK_W-1:0];
          default: ;
        endcase
      end

      taken <= start && !busy;
      if (start && !busy) begin
        accepted_count++;
        c.op    = operation;
        c.idx   = entry_index;
        c.ehash = entry_hash;
        c.bank  = bank_index;
        c.ofs   = offset_value;
        c.nbyte = name_byte;
        c.last  = last_byte;
        if (lookup_step(c, want)) lookup_expected.push_back(want);
      end
    end
  end

  // --------------------------------------------------------------------------
  // driver: one item per handshake, random gaps after each accepted item
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    cmd_t c;
    if (!start || taken) begin
      if (gap_left > 0 || pending_cmds.size() == 0) begin
        start <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        c = pending_cmds.pop_front();
        operation    <= c.op;
        entry_index  <= c.idx;
        entry_hash   <= c.ehash;
        bank_index   <= c.bank;
        offset_value <= c.ofs;
        name_byte    <= c.nbyte;
        last_byte    <= c.last;
        start        <= 1'b1;
        // mostly back to back or short gaps, now and then a long one,
        // and occasional stretches with no gaps at all
        if (calm_left > 0) begin
          calm_left--;
          gap_left = 0;
        end else if ($urandom_range(0, 39) == 0) begin
          calm_left = $urandom_range(20, 80);
          gap_left  = 0;
        end else if ($urandom_range(0, 9) < 6) begin
          gap_left = 0;
        end else if ($urandom_range(0, 19) == 0) begin
          gap_left = $urandom_range(10, 60);
        end else begin
          gap_left = $urandom_range(1, 3);
        end
      end
    end
  end

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL hashed_name_offset_lookup_core");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  // unused fields carry random junk, the core must not look at them
  function automatic cmd_t blank_cmd();
    cmd_t c;
    c.op    = OP_IGNORED;
    c.idx   = INDEX_W'($urandom);
    c.ehash = $urandom;
    c.bank  = BANK_W'($urandom);
    c.ofs   = OFFSET_W'($urandom);
    c.nbyte = BYTE_W'($urandom);
    c.last  = 1'($urandom);
    return c;
  endfunction

  function automatic logic [OFFSET_W-1:0] rand_offset();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return '1;                          // minus one
      1:       return {1'b1, 20'($urandom)};       // any negative value
      2:       return {1'b0, {20{1'b1}}};          // largest offset
      3:       return '0;
      default: return {1'b0, 20'($urandom)};
    endcase
  endfunction

  task automatic push_cmd(input cmd_t c);
    pending_cmds.push_back(c);
    pushed_count++;
    if (c.op == OP_IGNORED) ignored_count++;
  endtask

  task automatic queue_ignored();
    push_cmd(blank_cmd());
  endtask

  task automatic queue_write_hash(input int idx, input logic [HASH_W-1:0] h);
    cmd_t c;
    c       = blank_cmd();
    c.op    = OP_WRITE_HASH;
    c.idx   = idx[INDEX_W-1:0];
    c.ehash = h;
    gen_hash[idx] = h;
    push_cmd(c);
  endtask

  task automatic queue_write_offset(input int idx, input int bank, input logic [OFFSET_W-1:0] v);
    cmd_t c;
    c      = blank_cmd();
    c.op   = OP_WRITE_OFFSET;
    c.idx  = idx[INDEX_W-1:0];
    c.bank = bank[BANK_W-1:0];
    c.ofs  = v;
    if (bank < NUM_BANKS) ofs_written[idx*NUM_BANKS + bank] = 1'b1;
    push_cmd(c);
  endtask

  // noise that must leave the running hash alone
  task automatic queue_noise();
    int r;
    r = $urandom_range(0, 2);
    if (r == 0) begin
      queue_ignored();
    end else if (r == 1) begin
      queue_write_offset($urandom_range(0, MAX_ENTRIES-1), $urandom_range(0, 15), rand_offset());
    end else if (table_size < MAX_ENTRIES) begin
      queue_write_hash($urandom_range(table_size, MAX_ENTRIES-1), $urandom);
    end else begin
      queue_ignored();
    end
  endtask

  // a name as a run of bytes, the bank rides on the last one
  task automatic queue_name(input logic [63:0] word, input int len, input int bank,
                            input bit noisy);
    cmd_t c;
    for (int k = 0; k < len; k++) begin
      if (noisy && len > 1 && k == len - 1) queue_noise();
      c       = blank_cmd();
      c.op    = OP_NAME_BYTE;
      c.nbyte = word[8*k +: 8];
      c.last  = (k == len - 1);
      if (c.last) c.bank = bank[BANK_W-1:0];
      push_cmd(c);
    end
  endtask

  // block until every item is in and every lookup answered, then let it settle
  task automatic wait_idle();
    do @(negedge clk); while (accepted_count != pushed_count || lookup_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // new register setting plus a freshly sorted table of random names;
  // every entry and offset a lookup could touch is written before use
  task automatic setup_phase(input int n, input int bc, input int mask);
    logic [HASH_W-1:0] th[MAX_ENTRIES];
    logic [HASH_W-1:0] key_h;
    logic [63:0]       key_w;
    int                key_l, j, m;
    wait_idle();
    write_config(CFG_ENTRY_COUNT, n);
    write_config(CFG_BANK_COUNT, bc);
    write_config(CFG_BANK_MASK, mask);
    @(posedge clk);
    m          = (n > MAX_ENTRIES) ? MAX_ENTRIES : n;
    table_size = m;
    live_banks = (bc > NUM_BANKS) ? NUM_BANKS : bc;
    for (int i = 0; i < m; i++) begin
      name_word[i] = {$urandom, $urandom};
      name_len[i]  = $urandom_range(1, NAME_MAX);
      th[i]        = hash_of_name(name_word[i], name_len[i]);
    end
    // keep the table ascending
    for (int i = 1; i < m; i++) begin
      key_h = th[i];
      key_w = name_word[i];
      key_l = name_len[i];
      j = i - 1;
      while (j >= 0 && th[j] > key_h) begin
        th[j+1]        = th[j];
        name_word[j+1] = name_word[j];
        name_len[j+1]  = name_len[j];
        j--;
      end
      th[j+1]        = key_h;
      name_word[j+1] = key_w;
      name_len[j+1]  = key_l;
    end
    for (int i = 0; i < m; i++) queue_write_hash(i, th[i]);
    for (int i = 0; i < m; i++)
      for (int b = 0; b < live_banks; b++)
        if (!ofs_written[i*NUM_BANKS + b]) queue_write_offset(i, b, rand_offset());
  endtask

  // mostly whole names with random content, the rest writes and noise
  task automatic random_traffic(input int target);
    int first, r, k, bank, idx;
    first = pushed_count - ignored_count;
    while (pushed_count - ignored_count - first < target) begin
      r = $urandom_range(0, 99);
      if (live_banks > 0 && $urandom_range(0, 3) != 0) bank = $urandom_range(0, live_banks-1);
      else bank = $urandom_range(0, 15);
      if (r < 62) begin
        if (table_size > 0 && $urandom_range(0, 4) != 0) begin
          k = $urandom_range(0, table_size-1);
          queue_name(name_word[k], name_len[k], bank, $urandom_range(0, 9) == 0);
        end else begin
          queue_name({$urandom, $urandom}, $urandom_range(1, NAME_MAX), bank,
                     $urandom_range(0, 9) == 0);
        end
      end else if (r < 78) begin
        if (table_size > 0 && $urandom_range(0, 3) != 0) idx = $urandom_range(0, table_size-1);
        else idx = $urandom_range(0, MAX_ENTRIES-1);
        queue_write_offset(idx, $urandom_range(0, 15), rand_offset());
      end else if (r < 82) begin
        // overwrites can leave the table unsorted or with duplicates
        idx = $urandom_range(0, MAX_ENTRIES-1);
        if (idx < MAX_ENTRIES-1 && $urandom_range(0, 1) == 0)
          queue_write_hash(idx, gen_hash[idx+1]);
        else
          queue_write_hash(idx, $urandom);
      end else if (r < 87) begin
        queue_ignored();
      end else if (r < 93) begin
        // a broken name: bytes that never see a last flag
        queue_name({$urandom, $urandom}, $urandom_range(1, 3) + 1, bank, 1'b0);
        pending_cmds.pop_back();
        pushed_count--;
      end else begin
        queue_name({$urandom, $urandom}, 1, $urandom_range(0, 15), 1'b0);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // zero banks: every lookup is rejected before the table is touched
    setup_phase(0, 0, 0);
    queue_ignored();
    queue_write_hash(0, 32'h0000_0000);
    queue_write_hash(MAX_ENTRIES-1, 32'hffff_ffff);
    queue_write_offset(0, 0, '1);
    queue_write_offset(MAX_ENTRIES-1, NUM_BANKS-1, {1'b0, {20{1'b1}}});
    queue_write_offset(3, 15, rand_offset());   // bank past the end, dropped
    queue_name(64'h00, 1, 0, 1'b0);
    queue_name(64'h80ff, 2, 15, 1'b0);
    queue_name(64'h4241, 2, 0, 1'b1);           // noise in the middle of a name

    // empty table: valid banks answer unknown, bank 8 and up rejected
    setup_phase(0, 8, 8'hff);
    queue_name(64'h61, 1, 7, 1'b0);
    queue_name(64'h61, 1, 8, 1'b0);
    queue_name(64'hffee_ddcc_bbaa_9988, 8, 0, 1'b0);

    // small table with found and absent answers, bank 7 without storage
    setup_phase(8, 8, 8'h7f);
    queue_write_offset(0, 1, {1'b0, {20{1'b1}}});
    queue_name(name_word[0], name_len[0], 1, 1'b0);
    queue_write_offset(1, 2, '1);
    queue_name(name_word[1], name_len[1], 2, 1'b0);
    queue_write_offset(2, 7, 21'd5);
    queue_name(name_word[2], name_len[2], 7, 1'b0);
    queue_write_offset(7, 0, '0);
    queue_name(name_word[7], name_len[7], 0, 1'b0);
    queue_write_hash(4, gen_hash[3]);           // duplicate neighbor
    queue_name(name_word[3], name_len[3], 3, 1'b0);
    random_traffic(70);

    setup_phase(5, 3, 8'h05);
    random_traffic(60);
    setup_phase(1, 1, 8'h01);
    random_traffic(40);
    setup_phase(2, 2, 8'h00);                   // no bank has storage
    random_traffic(30);
    setup_phase(16, 15, 8'ha5);                 // bank count past the bank total
    random_traffic(70);
    setup_phase(MAX_ENTRIES, 1, 8'hff);         // full table
    random_traffic(70);
    setup_phase(511, 1, 8'hff);                 // entry count past the table size
    random_traffic(50);
    for (int p = 0; p < 3; p++) begin
      setup_phase($urandom_range(1, 24), $urandom_range(0, 15), $urandom_range(0, 255));
      random_traffic(40);
    end

    wait_idle();
    if (mismatch_count == 0 && lookup_expected.size() == 0) begin
      $display("PASS hashed_name_offset_lookup_core");
    end else begin
      $display("FAIL hashed_name_offset_lookup_core");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/hnol_pkg.sv
rtl/core/hnol_ram.sv
rtl/core/hnol_hash.sv
rtl/core/hnol_search.sv
rtl/core/hashed_name_offset_lookup_core.sv
sim/hashed_name_offset_lookup_core_tb.sv
